>>> design/zmvt_pkg.sv
// ----------------------------------------------------------------------------
// zmvt_pkg
// Shared constants and types for the zero-marked value table.
// ----------------------------------------------------------------------------
package zmvt_pkg;

    localparam int DATA_W      = 32;
    localparam int OP_W        = 3;
    localparam int ST_W        = 2;
    localparam int ENTRIES_DEF = 16;

    localparam logic [OP_W-1:0] OP_ADD     = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE  = 3'd1;
    localparam logic [OP_W-1:0] OP_REPLACE = 3'd2;
    localparam logic [OP_W-1:0] OP_AVERAGE = 3'd3;
    localparam logic [OP_W-1:0] OP_DEDUP   = 3'd4;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [DATA_W-1:0] avg;
    } zmvt_res_t;

endpackage

>>> design/zmvt_mem.sv
// ----------------------------------------------------------------------------
// zmvt_mem
// Single-port-read, single-port-write table store with registered read
// data. Per-entry valid bits make unwritten entries read as zero.
// ----------------------------------------------------------------------------
module zmvt_mem
    import zmvt_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF,
    parameter int IDX_W   = $clog2(ENTRIES)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              re,
    input  logic [IDX_W-1:0]  raddr,
    input  logic              we,
    input  logic [IDX_W-1:0]  waddr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [DATA_W-1:0] rd_data_reg;
    logic              rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rd_data_reg <= mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (we) begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re) begin
                rd_valid_reg <= valid_reg[raddr];
            end
        end
    end

    assign rdata = rd_valid_reg ? rd_data_reg : '0;

endmodule

>>> design/zmvt_div.sv
// ----------------------------------------------------------------------------
// zmvt_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module zmvt_div #(
    parameter int DW = 36,
    parameter int VW = 5
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int STEP_W = $clog2(DW + 1);

    logic [VW-1:0]     rem_reg;
    logic [DW-1:0]     quo_reg;
    logic [VW-1:0]     dvs_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [VW:0]       shifted;
    logic [VW+1:0]     diff;
    logic              fits;

    always_comb begin
        shifted = {rem_reg, quo_reg[DW-1]};
        diff    = {1'b0, shifted} - {2'b00, dvs_reg};
        fits    = !diff[VW+1];
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[VW-1:0] : shifted[VW-1:0];
            quo_reg <= {quo_reg[DW-2:0], fits};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(DW);
            end else if (busy_reg) begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> design/zmvt_seq.sv
// ----------------------------------------------------------------------------
// zmvt_seq
// Operation sequencer: walks the table store read-check-write, entry by
// entry, and drives the divider for the average.
// ----------------------------------------------------------------------------
module zmvt_seq
    import zmvt_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF,
    parameter int IDX_W   = $clog2(ENTRIES),
    parameter int CNT_W   = $clog2(ENTRIES + 1),
    parameter int SUM_W   = DATA_W + $clog2(ENTRIES)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              req_valid,
    output logic              req_ready,
    input  logic [OP_W-1:0]   req_op,
    input  logic [DATA_W-1:0] req_value,
    input  logic [DATA_W-1:0] req_new_value,
    output logic              res_valid,
    input  logic              res_ready,
    output zmvt_res_t         res,
    output logic              mem_re,
    output logic [IDX_W-1:0]  mem_raddr,
    output logic              mem_we,
    output logic [IDX_W-1:0]  mem_waddr,
    output logic [DATA_W-1:0] mem_wdata,
    input  logic [DATA_W-1:0] mem_rdata,
    output logic              div_start,
    output logic [SUM_W-1:0]  div_dividend,
    output logic [CNT_W-1:0]  div_divisor,
    input  logic              div_done,
    input  logic [SUM_W-1:0]  div_quotient
);

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_CHK, S_KEY_RD, S_KEY_CHK, S_DIV_START, S_DIV_WAIT, S_DONE
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    state_t            state_reg, state_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [DATA_W-1:0] nv_reg, nv_next;
    logic [DATA_W-1:0] key_reg, key_next;
    logic [IDX_W-1:0]  addr_reg, addr_next;
    logic [IDX_W-1:0]  key_addr_reg, key_addr_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              hit_reg, hit_next;
    logic              neg_reg, neg_next;
    logic [ST_W-1:0]   status_reg, status_next;
    logic [DATA_W-1:0] avg_reg, avg_next;
    logic              last;
    logic              match;
    logic              nonzero;
    logic [DATA_W-1:0] quo_lo;

    always_comb begin
        last    = (addr_reg == LAST_IDX);
        match   = (mem_rdata == val_reg);
        nonzero = (mem_rdata != '0);
        quo_lo  = div_quotient[DATA_W-1:0];

        state_next    = state_reg;
        op_next       = op_reg;
        val_next      = val_reg;
        nv_next       = nv_reg;
        key_next      = key_reg;
        addr_next     = addr_reg;
        key_addr_next = key_addr_reg;
        sum_next      = sum_reg;
        cnt_next      = cnt_reg;
        hit_next      = hit_reg;
        neg_next      = neg_reg;
        status_next   = status_reg;
        avg_next      = avg_reg;

        mem_re       = 1'b0;
        mem_raddr    = addr_reg;
        mem_we       = 1'b0;
        mem_waddr    = addr_reg;
        mem_wdata    = '0;
        div_start    = 1'b0;
        div_dividend = sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
        div_divisor  = cnt_reg;

        case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    op_next       = req_op;
                    val_next      = req_value;
                    nv_next       = req_new_value;
                    addr_next     = '0;
                    key_addr_next = '0;
                    sum_next      = '0;
                    cnt_next      = '0;
                    hit_next      = 1'b0;
                    status_next   = ST_OK;
                    avg_next      = '0;
                    case (req_op)
                        OP_ADD, OP_REMOVE, OP_REPLACE, OP_AVERAGE: state_next = S_RD;
                        OP_DEDUP: state_next = S_KEY_RD;
                        default:  state_next = S_DONE;
                    endcase
                end
            end
            S_RD: begin
                mem_re     = 1'b1;
                state_next = S_CHK;
            end
            S_CHK: begin
                addr_next  = addr_reg + 1'b1;
                state_next = last ? S_DONE : S_RD;
                case (op_reg)
                    OP_ADD: begin
                        if (!nonzero) begin
                            mem_we     = 1'b1;
                            mem_wdata  = val_reg;
                            state_next = S_DONE;
                        end else if (last) begin
                            status_next = ST_FULL;
                        end
                    end
                    OP_REMOVE: begin
                        mem_we = match;
                    end
                    OP_REPLACE: begin
                        mem_we    = match;
                        mem_wdata = nv_reg;
                        hit_next  = hit_reg | match;
                        if (last && !(hit_reg | match)) begin
                            status_next = ST_NOT_FOUND;
                        end
                    end
                    OP_AVERAGE: begin
                        if (nonzero) begin
                            sum_next = sum_reg + {{(SUM_W-DATA_W){mem_rdata[DATA_W-1]}},
                                                  mem_rdata};
                            cnt_next = cnt_reg + 1'b1;
                        end
                        if (last) begin
                            if (cnt_reg == '0 && !nonzero) begin
                                status_next = ST_EMPTY;
                            end else begin
                                state_next = S_DIV_START;
                            end
                        end
                    end
                    OP_DEDUP: begin
                        mem_we = (mem_rdata == key_reg);
                        if (last) begin
                            key_addr_next = key_addr_reg + 1'b1;
                            state_next    = S_KEY_RD;
                        end
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_KEY_RD: begin
                mem_re     = 1'b1;
                mem_raddr  = key_addr_reg;
                state_next = S_KEY_CHK;
            end
            S_KEY_CHK: begin
                key_next = mem_rdata;
                if (key_addr_reg == LAST_IDX) begin
                    state_next = S_DONE;
                end else if (!nonzero) begin
                    key_addr_next = key_addr_reg + 1'b1;
                    state_next    = S_KEY_RD;
                end else begin
                    addr_next  = key_addr_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_DIV_START: begin
                div_start  = 1'b1;
                neg_next   = sum_reg[SUM_W-1];
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    avg_next   = neg_reg ? (~quo_lo + 1'b1) : quo_lo;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        op_reg       <= op_next;
        val_reg      <= val_next;
        nv_reg       <= nv_next;
        key_reg      <= key_next;
        addr_reg     <= addr_next;
        key_addr_reg <= key_addr_next;
        sum_reg      <= sum_next;
        cnt_reg      <= cnt_next;
        hit_reg      <= hit_next;
        neg_reg      <= neg_next;
        status_reg   <= status_next;
        avg_reg      <= avg_next;
    end

    assign req_ready  = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_DONE);
    assign res.status = status_reg;
    assign res.avg    = avg_reg;

endmodule

>>> design/zero_marked_value_table_core.sv
// ----------------------------------------------------------------------------
// zero_marked_value_table_core
// Table of signed 32-bit entries, zero meaning empty, with add, remove,
// replace, average and dedup requests; one result per request.
// ----------------------------------------------------------------------------
// One request is worked at a time. The table sits in a memory with registered
// read data that is read, checked and written back entry by entry: add
// stops at the first empty slot, remove and replace walk the whole table,
// average walks it and then, unless it is empty, runs the one-bit-per-cycle
// divider, and dedup checks each nonempty entry against the entries after
// it. Unused operation codes return at once. The table reads as empty right
// after reset; no clearing pass is needed. A finished result waits in the
// output register while the next request is accepted.
// ----------------------------------------------------------------------------
module zero_marked_value_table_core
    import zmvt_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] value, [63:32] new_value
    input  logic [2:0]  s_tuser,   // [2:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] average_value
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int SUM_W = DATA_W + $clog2(ENTRIES);

    logic              mem_re;
    logic [IDX_W-1:0]  mem_raddr;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [DATA_W-1:0] mem_rdata;
    logic              div_start;
    logic [SUM_W-1:0]  div_dividend;
    logic [CNT_W-1:0]  div_divisor;
    logic              div_done;
    logic [SUM_W-1:0]  div_quotient;
    logic              seq_res_valid;
    logic              seq_res_ready;
    zmvt_res_t         seq_res;
    logic              m_tvalid_reg;
    zmvt_res_t         m_res_reg;

    zmvt_mem #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .re      (mem_re),
        .raddr   (mem_raddr),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .rdata   (mem_rdata)
    );

    zmvt_div #(
        .DW (SUM_W),
        .VW (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    zmvt_seq #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W),
        .CNT_W   (CNT_W),
        .SUM_W   (SUM_W)
    ) u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .req_valid     (s_tvalid),
        .req_ready     (s_tready),
        .req_op        (s_tuser),
        .req_value     (s_tdata[31:0]),
        .req_new_value (s_tdata[63:32]),
        .res_valid     (seq_res_valid),
        .res_ready     (seq_res_ready),
        .res           (seq_res),
        .mem_re        (mem_re),
        .mem_raddr     (mem_raddr),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .mem_rdata     (mem_rdata),
        .div_start     (div_start),
        .div_dividend  (div_dividend),
        .div_divisor   (div_divisor),
        .div_done      (div_done),
        .div_quotient  (div_quotient)
    );

    assign seq_res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (seq_res_ready) begin
            m_tvalid_reg <= seq_res_valid;
        end
        if (seq_res_ready && seq_res_valid) begin
            m_res_reg <= seq_res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_res_reg.avg;
    assign m_tuser  = m_res_reg.status;

`ifndef SYNTHESIS
    a_err_zero_avg: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_OK) |-> (m_tdata == '0))
        else $error("nonzero average with error status");

    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("sequencer idle right after taking a request");

    a_res_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (seq_res_valid && !seq_res_ready) |=> (seq_res_valid && $stable(seq_res)))
        else $error("pending result lost while output register full");

    a_no_rd_wr_mix: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_re && mem_we))
        else $error("memory read and write in the same cycle");
`endif

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for zero_marked_value_table_core. Directed requests hit the
// empty, full and wide-sum corners and the unused operation codes, then a
// long random mix draws values from a small pool so that adds, removes,
// replaces and dedups keep finding matches. A shadow table predicts every
// result, which is checked in order against the output stream while both
// sides of the stream stall at random.
// ----------------------------------------------------------------------------
module tb;
    import zmvt_pkg::*;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int DRAIN_CYCLES = 300;
    localparam int STALL_CYCLES = 400;
    localparam int RANDOM_REQS = 700;
    localparam int POOL_SIZE = 8;
    localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_LAST = 3'd7;
    localparam logic [DATA_W-1:0] MAX_POS = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] MIN_NEG = 32'h8000_0000;
    localparam logic [DATA_W-1:0] MINUS_ONE = 32'hFFFF_FFFF;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // [31:0] value, [63:32] new_value
    logic [2:0]  s_tuser;   // [2:0] operation
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [31:0] average_value
    logic [1:0]  m_tuser;   // [1:0] status

    logic [DATA_W-1:0] table_shadow [ENTRIES_DEF];
    logic [DATA_W-1:0] value_pool [POOL_SIZE];
    zmvt_res_t         pending_results [$];
    zmvt_res_t         oldest;
    int                mismatch_count = 0;
    int                cycle_count = 0;
    int                hold_left = 0;
    bit                no_idle = 0;

    zero_marked_value_table_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic zmvt_res_t predict_table_op(logic [OP_W-1:0] op,
                                                   logic [DATA_W-1:0] v,
                                                   logic [DATA_W-1:0] nv);
        zmvt_res_t res;
        logic placed;
        logic hit;
        logic signed [DATA_W-1:0] entry;
        logic signed [63:0] sum;
        logic signed [63:0] count;
        logic signed [63:0] mean;
        res.status = ST_OK;
        res.avg = '0;
        case (op)
            OP_ADD: begin
                placed = 1'b0;
                for (int i = 0; i < ENTRIES_DEF; i++) begin
                    if (!placed && table_shadow[i] == '0) begin
                        table_shadow[i] = v;
                        placed = 1'b1;
                    end
                end
                if (!placed) res.status = ST_FULL;
            end
            OP_REMOVE: begin
                for (int i = 0; i < ENTRIES_DEF; i++)
                    if (table_shadow[i] == v) table_shadow[i] = '0;
            end
            OP_REPLACE: begin
                hit = 1'b0;
                for (int i = 0; i < ENTRIES_DEF; i++) begin
                    if (table_shadow[i] == v) begin
                        table_shadow[i] = nv;
                        hit = 1'b1;
                    end
                end
                if (!hit) res.status = ST_NOT_FOUND;
            end
            OP_AVERAGE: begin
                sum = 0;
                count = 0;
                for (int i = 0; i < ENTRIES_DEF; i++) begin
                    if (table_shadow[i] != '0) begin
                        entry = table_shadow[i];
                        sum = sum + entry;
                        count = count + 1;
                    end
                end
                if (count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    mean = sum / count;
                    res.avg = mean[DATA_W-1:0];
                end
            end
            OP_DEDUP: begin
                for (int i = 0; i < ENTRIES_DEF; i++) begin
                    if (table_shadow[i] != '0) begin
                        for (int x = i + 1; x < ENTRIES_DEF; x++)
                            if (table_shadow[x] == table_shadow[i]) table_shadow[x] = '0;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("MISMATCH %s: got %h, want %h at %0t ns", what, got, want, $time);
    endtask

    // all inputs move only at rising edges, so the falling edge sees the
    // values that the next rising edge will take
    always @(negedge aclk) begin
        if (m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request pending", m_tdata, '0);
            end else begin
                oldest = pending_results.pop_front();
                if (m_tuser !== oldest.status)
                    report_mismatch("status", 32'(m_tuser), 32'(oldest.status));
                if (m_tdata !== oldest.avg)
                    report_mismatch("average_value", m_tdata, oldest.avg);
            end
        end
    end

    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (no_idle) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= 21);
            end
        end
    end

    task automatic send_req(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] v,
                            input logic [DATA_W-1:0] nv);
        logic took;
        if (!no_idle && $urandom_range(99) < 21) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(12, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {nv, v};
        s_tuser <= op;
        do begin
            @(negedge aclk);
            took = s_tready;
            @(posedge aclk);
        end while (!took);
        pending_results.push_back(predict_table_op(op, v, nv));
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic test_empty_table();
        send_req(OP_AVERAGE, $urandom, $urandom);
        send_req(OP_DEDUP, $urandom, $urandom);
        send_req(OP_REMOVE, '0, $urandom);
        send_req(OP_ADD, '0, $urandom);
        wait_drain();
    endtask

    task automatic test_extremes();
        send_req(OP_ADD, MAX_POS, '0);
        send_req(OP_ADD, MIN_NEG, '0);
        send_req(OP_ADD, MIN_NEG, '0);
        send_req(OP_ADD, MINUS_ONE, '0);
        send_req(OP_AVERAGE, '0, '0);
        wait_drain();
    endtask

    task automatic test_replace_remove();
        send_req(OP_REPLACE, 32'd12345, 32'd7);
        send_req(OP_REPLACE, MIN_NEG, MAX_POS);
        send_req(OP_REMOVE, MAX_POS, MINUS_ONE);
        wait_drain();
    endtask

    task automatic test_unused_ops();
        for (int op = OP_UNUSED_FIRST; op <= OP_UNUSED_LAST; op++)
            send_req(op[OP_W-1:0], $urandom, $urandom);
        wait_drain();
    endtask

    task automatic test_full_table();
        send_req(OP_REPLACE, '0, 32'd5);
        send_req(OP_ADD, 32'd9, '0);
        send_req(OP_ADD, '0, '0);
        send_req(OP_REPLACE, '0, 32'd1);
        send_req(OP_AVERAGE, '0, '0);
        wait_drain();
    endtask

    task automatic test_dedup();
        send_req(OP_DEDUP, '0, '0);
        send_req(OP_AVERAGE, '0, '0);
        wait_drain();
    endtask

    task automatic test_wide_sum();
        send_req(OP_REPLACE, '0, MIN_NEG);
        send_req(OP_AVERAGE, '0, '0);
        send_req(OP_REMOVE, MIN_NEG, '0);
        wait_drain();
    endtask

    task automatic test_output_stall();
        no_idle = 1;
        hold_left = STALL_CYCLES;
        for (int n = 0; n < 12; n++)
            send_req((n % 3 == 0) ? OP_AVERAGE : OP_ADD, $urandom_range(20, 1), '0);
        wait_drain();
        no_idle = 0;
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 75) return value_pool[$urandom_range(POOL_SIZE - 1)];
        if (r < 85) return '0;
        return $urandom;
    endfunction

    task automatic test_random_mix();
        int r;
        logic [OP_W-1:0] op;
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n % 100 == 0) begin
                value_pool[0] = MIN_NEG;
                value_pool[1] = MAX_POS;
                value_pool[2] = MINUS_ONE;
                value_pool[3] = $urandom_range(5, 1);
                for (int k = 4; k < POOL_SIZE; k++) value_pool[k] = $urandom;
            end
            if (n == 250) no_idle = 1;
            if (n == 380) no_idle = 0;
            r = $urandom_range(99);
            if (r < 40) op = OP_ADD;
            else if (r < 55) op = OP_REMOVE;
            else if (r < 70) op = OP_REPLACE;
            else if (r < 85) op = OP_AVERAGE;
            else if (r < 93) op = OP_DEDUP;
            else op = OP_W'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
            send_req(op, pick_value(), pick_value());
        end
        wait_drain();
    endtask

    initial begin
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        for (int i = 0; i < ENTRIES_DEF; i++) table_shadow[i] = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_table();
        test_extremes();
        test_replace_remove();
        test_unused_ops();
        test_full_table();
        test_dedup();
        test_wide_sum();
        test_output_stall();
        test_random_mix();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> files.f
design/zmvt_pkg.sv
design/zmvt_mem.sv
design/zmvt_div.sv
design/zmvt_seq.sv
design/zero_marked_value_table_core.sv
sim/tb.sv
